// ----- src/qpack_decoder_instruction_encoder_macros.svh -----
// ----------------------------------------------------------------------------
// qpack decoder instruction encoder assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef QPACK_DECODER_INSTRUCTION_ENCODER_MACROS_SVH
`define QPACK_DECODER_INSTRUCTION_ENCODER_MACROS_SVH

// property checked outside reset only
`define QPDE_ASSERT(label, clk_s, rstn_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error(msg);

// property checked on every edge, reset included
`define QPDE_ASSERT_ALWAYS(label, clk_s, prop, msg) \
    label: assert property (@(posedge clk_s) prop) \
        else $error(msg);

`endif

// ----- src/qpde_pkg.sv -----
// ----------------------------------------------------------------------------
// qpde_pkg
// shared types, codes and constants of the decoder stream instruction encoder
// ----------------------------------------------------------------------------
package qpde_pkg;

    localparam int OPERAND_W  = 62;
    localparam int CAP_W      = 16;
    localparam int TOTAL_W    = 64;
    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam int DEF_MAX_ENCODED_BYTES = 11;
    localparam int DEF_VALUE_BITS        = 62;
    localparam int MAX_RESULTS           = 10;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd4096;

    // register index, taken from paddr above the byte offset
    localparam logic [0:0] REG_BUFFER_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        KIND_OPEN   = 3'd0,
        KIND_CLOSE  = 3'd1,
        KIND_RESET  = 3'd2,
        KIND_ACK    = 3'd3,
        KIND_CANCEL = 3'd4,
        KIND_INCR   = 3'd5,
        KIND_MARK   = 3'd6,
        KIND_CLEAR  = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_FULL    = 3'd2,
        ST_DUP     = 3'd3,
        ST_CLOSED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        LINK_IDLE   = 2'd0,
        LINK_OPEN   = 2'd1,
        LINK_CLOSED = 2'd2
    } link_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PREP  = 5'b00010,
        S_CHECK = 5'b00100,
        S_EMIT  = 5'b01000,
        S_STAT  = 5'b10000
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic commit;
        logic load_byte;
        logic load_status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;
        logic last_byte;
        logic out_free;
    } sts_t;

endpackage

// ----- src/qpack_decoder_instruction_encoder.sv -----
// ----------------------------------------------------------------------------
// qpack_decoder_instruction_encoder
// QPACK decoder stream command to prefix-integer byte encoder
// ----------------------------------------------------------------------------
// One command item (kind, operand) enters on the in_valid/in_stall channel.
// It yields either the bytes of one decoder stream instruction, one result
// item per byte with last on the final one, or a single status item with
// byte_valid low. Every result item carries the link state and counters as
// they stand after the command.
// Steps: capture, the prefix subtraction, then length, credit check and state
// update, then one byte per cycle out of the shift register into the output
// register whenever out_stall does not hold it. There are 1 to 10 result items.
// A finished result waits in the output register while the next item is
// accepted. When out_stall is high while a result is held, the output register
// holds and emission pauses. Reset returns to the idle link with all counters
// at zero and the buffer capacity at 4096. The capacity register is written
// over the APB port at address 0; the user must write it only while no item is
// in flight, the block itself does not enforce this.
// ----------------------------------------------------------------------------
module qpack_decoder_instruction_encoder
    import qpde_pkg::*;
#(
    parameter int MAX_ENCODED_BYTES = DEF_MAX_ENCODED_BYTES,
    parameter int VALUE_BITS        = DEF_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            kind,
    input  logic [OPERAND_W-1:0]  operand,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [BYTE_W-1:0]     out_byte,
    output logic                  byte_valid,
    output logic                  last,
    output logic [2:0]            status,
    output logic [1:0]            link_state,
    output logic [CAP_W-1:0]      pending_bytes,
    output logic [TOTAL_W-1:0]    known_count,
    output logic [OPERAND_W-1:0]  max_ack_id,
    output logic [OPERAND_W-1:0]  open_stream_id
);

    cmd_t             cmd;
    sts_t             sts;
    logic             cfg_we;
    logic             cfg_hit;
    logic [CAP_W-1:0] capacity;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == REG_BUFFER_CAPACITY);
    assign cfg_we  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? CFG_DATA_W'(capacity) : '0;

    qpde_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    qpde_dp
    #(
        .MAX_ENCODED_BYTES (MAX_ENCODED_BYTES),
        .VALUE_BITS        (VALUE_BITS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .kind           (kind),
        .operand        (operand),
        .cfg_we         (cfg_we),
        .cfg_wdata      (pwdata[CAP_W-1:0]),
        .capacity       (capacity),
        .cmd            (cmd),
        .sts            (sts),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .last           (last),
        .status         (status),
        .link_state     (link_state),
        .pending_bytes  (pending_bytes),
        .known_count    (known_count),
        .max_ack_id     (max_ack_id),
        .open_stream_id (open_stream_id)
    );

endmodule

// ----- src/qpde_ctrl.sv -----
// ----------------------------------------------------------------------------
// qpde_ctrl
// sequencer: capture, prefix prep, decision, byte or status emission
// ----------------------------------------------------------------------------
module qpde_ctrl
    import qpde_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.commit = 1'b1;
                state_next = sts.emit ? S_EMIT : S_STAT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_byte = 1'b1;
                    if (sts.last_byte)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_STAT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/qpde_dp.sv -----
// ----------------------------------------------------------------------------
// qpde_dp
// link state, counters, prefix integer encoder and output register
// ----------------------------------------------------------------------------
module qpde_dp
    import qpde_pkg::*;
#(
    parameter int MAX_ENCODED_BYTES = DEF_MAX_ENCODED_BYTES,
    parameter int VALUE_BITS        = DEF_VALUE_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           kind,
    input  logic [OPERAND_W-1:0] operand,
    input  logic                 cfg_we,
    input  logic [CAP_W-1:0]     cfg_wdata,
    output logic [CAP_W-1:0]     capacity,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 byte_valid,
    output logic                 last,
    output logic [2:0]           status,
    output logic [1:0]           link_state,
    output logic [CAP_W-1:0]     pending_bytes,
    output logic [TOTAL_W-1:0]   known_count,
    output logic [OPERAND_W-1:0] max_ack_id,
    output logic [OPERAND_W-1:0] open_stream_id
);

    localparam int OPND_W   = (VALUE_BITS < OPERAND_W) ? VALUE_BITS : OPERAND_W;
    localparam int NGROUPS  = (OPND_W + 6) / 7;
    localparam int REM_W    = NGROUPS * 7;
    localparam int GRP_W    = $clog2(NGROUPS);
    localparam int LEN_W    = $clog2(MAX_ENCODED_BYTES + 1);
    localparam int SEL_W    = (GRP_W > LEN_W) ? GRP_W : LEN_W;
    localparam int CONT_MAX = MAX_ENCODED_BYTES - 2;
    localparam int CMP_W    = (OPND_W > CAP_W) ? OPND_W : CAP_W;

    localparam logic [BYTE_W-1:0] CONT_FLAG = 8'h80;
    localparam logic [6:0]        LOW7      = 7'h7F;
    localparam logic [5:0]        LOW6      = 6'h3F;

    // configuration and tracked state
    logic [CAP_W-1:0]   cap_reg;
    link_t              link_reg,    link_next;
    logic [OPND_W-1:0]  saved_reg,   saved_next;
    logic [CAP_W-1:0]   pending_reg, pending_next;
    logic [TOTAL_W-1:0] total_reg,   total_next;
    logic [OPND_W-1:0]  ack_reg,     ack_next;

    // item in flight
    kind_t              kind_reg;
    logic [OPND_W-1:0]  opnd_reg;
    logic               small_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [LEN_W-1:0]   idx_reg;
    logic [LEN_W-1:0]   last_idx_reg;
    status_t            code_reg;

    // output register
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               byte_valid_reg;
    logic               last_reg;
    status_t            status_reg;
    link_t              link_out_reg;
    logic [CAP_W-1:0]   pending_out_reg;
    logic [TOTAL_W-1:0] total_out_reg;
    logic [OPERAND_W-1:0] ack_out_reg;
    logic [OPERAND_W-1:0] open_out_reg;

    logic [OPND_W-1:0]  pmax;
    logic [OPND_W-1:0]  diff;
    logic [GRP_W-1:0]   top_grp;
    logic [SEL_W-1:0]   cont;
    logic [LEN_W-1:0]   len;
    logic               fits;
    logic [CMP_W-1:0]   opnd_cmp;
    logic               emit;
    status_t            code;
    logic [BYTE_W-1:0]  first_byte;
    logic [BYTE_W-1:0]  next_byte;

    assign capacity = cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // capture and prefix prep
    // ------------------------------------------------------------------
    assign pmax = (kind_reg == KIND_ACK) ? OPND_W'(LOW7) : OPND_W'(LOW6);
    assign diff = opnd_reg - pmax;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(kind);
            opnd_reg <= operand[OPND_W-1:0];
        end
        if (cmd.prep)
        begin
            small_reg <= (opnd_reg < pmax);
            rem_reg   <= REM_W'(diff);
        end
        else if (cmd.load_byte && (idx_reg != '0))
        begin
            rem_reg <= {7'd0, rem_reg[REM_W-1:7]};
        end
    end

    // ------------------------------------------------------------------
    // encoded length: highest nonzero 7-bit group of the remainder
    // ------------------------------------------------------------------
    always_comb
    begin
        top_grp = '0;
        for (int g = 1; g < NGROUPS; g++)
        begin
            if (|rem_reg[g*7 +: 7])
            begin
                top_grp = GRP_W'(g);
            end
        end
    end

    always_comb
    begin
        cont = (SEL_W'(top_grp) > SEL_W'(CONT_MAX)) ? SEL_W'(CONT_MAX) : SEL_W'(top_grp);
        len  = small_reg ? LEN_W'(1) : (LEN_W'(cont) + LEN_W'(2));
        fits = (int'(len) <= MAX_RESULTS) &&
               (({1'b0, pending_reg} + (CAP_W+1)'(len)) <= {1'b0, cap_reg});
    end

    assign opnd_cmp = CMP_W'(opnd_reg);

    // ------------------------------------------------------------------
    // command decision and state update
    // ------------------------------------------------------------------
    always_comb
    begin
        link_next    = link_reg;
        saved_next   = saved_reg;
        pending_next = pending_reg;
        total_next   = total_reg;
        ack_next     = ack_reg;
        emit         = 1'b0;
        code         = ST_OK;
        unique case (kind_reg)
            KIND_OPEN:
            begin
                if (link_reg == LINK_OPEN)
                begin
                    code = ST_DUP;
                end
                else if (link_reg == LINK_CLOSED)
                begin
                    code = ST_CLOSED;
                end
                else
                begin
                    saved_next = opnd_reg;
                    link_next  = LINK_OPEN;
                end
            end
            KIND_CLOSE:
            begin
                link_next = LINK_CLOSED;
            end
            KIND_RESET:
            begin
                link_next    = LINK_IDLE;
                saved_next   = '0;
                pending_next = '0;
                total_next   = '0;
                ack_next     = '0;
            end
            KIND_MARK:
            begin
                if (opnd_cmp >= CMP_W'(pending_reg))
                begin
                    pending_next = '0;
                end
                else
                begin
                    pending_next = pending_reg - opnd_cmp[CAP_W-1:0];
                end
            end
            KIND_CLEAR:
            begin
                pending_next = '0;
            end
            KIND_ACK, KIND_CANCEL, KIND_INCR:
            begin
                if (link_reg != LINK_OPEN)
                begin
                    code = ST_INVALID;
                end
                else if ((kind_reg == KIND_INCR) && (opnd_reg == '0))
                begin
                    code = ST_OK;
                end
                else if (!fits)
                begin
                    code = ST_FULL;
                end
                else
                begin
                    emit         = 1'b1;
                    pending_next = pending_reg + CAP_W'(len);
                    if ((kind_reg == KIND_ACK) && (opnd_reg > ack_reg))
                    begin
                        ack_next = opnd_reg;
                    end
                    if (kind_reg == KIND_INCR)
                    begin
                        total_next = total_reg + TOTAL_W'(opnd_reg);
                    end
                end
            end
            default:
            begin
                code = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg    <= LINK_IDLE;
            saved_reg   <= '0;
            pending_reg <= '0;
            total_reg   <= '0;
            ack_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            link_reg    <= link_next;
            saved_reg   <= saved_next;
            pending_reg <= pending_next;
            total_reg   <= total_next;
            ack_reg     <= ack_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            code_reg     <= code;
            last_idx_reg <= len - LEN_W'(1);
            idx_reg      <= '0;
        end
        else if (cmd.load_byte)
        begin
            idx_reg <= idx_reg + LEN_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // byte selection
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (kind_reg)
            KIND_ACK:
                first_byte = {1'b1, small_reg ? opnd_reg[6:0] : LOW7};
            KIND_CANCEL:
                first_byte = {2'b01, small_reg ? opnd_reg[5:0] : LOW6};
            default:
                first_byte = {2'b00, small_reg ? opnd_reg[5:0] : LOW6};
        endcase
        if (idx_reg == '0)
        begin
            next_byte = first_byte;
        end
        else if (idx_reg == last_idx_reg)
        begin
            next_byte = rem_reg[BYTE_W-1:0];
        end
        else
        begin
            next_byte = CONT_FLAG | {1'b0, rem_reg[6:0]};
        end
    end

    // ------------------------------------------------------------------
    // output register with snapshot of the state after the step
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_byte || cmd.load_status)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte || cmd.load_status)
        begin
            out_byte_reg    <= cmd.load_byte ? next_byte : '0;
            byte_valid_reg  <= cmd.load_byte;
            last_reg        <= cmd.load_status || (idx_reg == last_idx_reg);
            status_reg      <= cmd.load_byte ? ST_OK : code_reg;
            link_out_reg    <= link_reg;
            pending_out_reg <= pending_reg;
            total_out_reg   <= total_reg;
            ack_out_reg     <= OPERAND_W'(ack_reg);
            open_out_reg    <= (link_reg == LINK_OPEN) ? OPERAND_W'(saved_reg) : '0;
        end
    end

    assign sts.emit      = emit;
    assign sts.last_byte = (idx_reg == last_idx_reg);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign byte_valid     = byte_valid_reg;
    assign last           = last_reg;
    assign status         = status_reg;
    assign link_state     = link_out_reg;
    assign pending_bytes  = pending_out_reg;
    assign known_count    = total_out_reg;
    assign max_ack_id     = ack_out_reg;
    assign open_stream_id = open_out_reg;

endmodule

// ----- src/qpde_chk.sv -----
// ----------------------------------------------------------------------------
// qpde_chk
// port-level checks on the result channel of the instruction encoder
// ----------------------------------------------------------------------------
`include "qpack_decoder_instruction_encoder_macros.svh"

module qpde_chk
    import qpde_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [BYTE_W-1:0]    out_byte,
    input logic                 byte_valid,
    input logic                 last,
    input logic [2:0]           status,
    input logic [1:0]           link_state,
    input logic [OPERAND_W-1:0] open_stream_id
);

    `QPDE_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !out_valid, "item shown during reset")

    `QPDE_ASSERT(a_byte_ok, clk, rst_n, (out_valid && byte_valid) |-> (status == ST_OK), "byte item with error status")

    `QPDE_ASSERT(a_status_single, clk, rst_n, (out_valid && !byte_valid) |-> (last && (out_byte == 8'h00)), "status item not final or carries a byte")

    `QPDE_ASSERT(a_stream_id_open, clk, rst_n, (out_valid && (link_state != LINK_OPEN)) |-> (open_stream_id == '0), "stream id shown while link not open")

    `QPDE_ASSERT(a_stall_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(last)), "stalled item changed")

endmodule

bind qpack_decoder_instruction_encoder qpde_chk u_chk (.*);

// ----- bench/qpde_encoder_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpde_encoder_check
// watches the command and byte channels of the decoder stream encoder,
// predicts every result item from its own copy of the link state and the
// capacity register, and counts mismatches
// ----------------------------------------------------------------------------
module qpde_encoder_check
    import qpde_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic [CFG_DATA_W-1:0] prdata,
    input  logic                  pready,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [2:0]            kind,
    input  logic [OPERAND_W-1:0]  operand,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [BYTE_W-1:0]     out_byte,
    input  logic                  byte_valid,
    input  logic                  last,
    input  logic [2:0]            status,
    input  logic [1:0]            link_state,
    input  logic [CAP_W-1:0]      pending_bytes,
    input  logic [TOTAL_W-1:0]    known_count,
    input  logic [OPERAND_W-1:0]  max_ack_id,
    input  logic [OPERAND_W-1:0]  open_stream_id,
    output int                    errors,
    output int                    results_awaited
);

    typedef struct packed {
        logic [BYTE_W-1:0]    data;
        logic                 has_byte;
        logic                 is_last;
        status_t              code;
        link_t                link;
        logic [CAP_W-1:0]     pend;
        logic [TOTAL_W-1:0]   total;
        logic [OPERAND_W-1:0] ack;
        logic [OPERAND_W-1:0] sid;
    } out_item_t;

    out_item_t            out_items_q[$];

    logic [CAP_W-1:0]     capacity;
    link_t                link_mode;
    logic [OPERAND_W-1:0] open_sid;
    logic [CAP_W-1:0]     pend_count;
    logic [TOTAL_W-1:0]   recv_total;
    logic [OPERAND_W-1:0] top_ack;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    task automatic push_result(input logic [BYTE_W-1:0] data, input logic has_byte,
                               input logic is_last, input status_t code);
        out_item_t r;
        r.data     = data;
        r.has_byte = has_byte;
        r.is_last  = is_last;
        r.code     = code;
        r.link     = link_mode;
        r.pend     = pend_count;
        r.total    = recv_total;
        r.ack      = top_ack;
        r.sid      = (link_mode == LINK_OPEN) ? open_sid : '0;
        out_items_q.push_back(r);
    endtask

    // applies one command to the local state and queues the items it yields
    task automatic encode_command(input kind_t k, input logic [OPERAND_W-1:0] v);
        logic [BYTE_W-1:0]    enc [0:DEF_MAX_ENCODED_BYTES-1];
        int                   n;
        status_t              st;
        logic [BYTE_W-1:0]    pattern;
        logic [OPERAND_W-1:0] pmax;
        logic [OPERAND_W-1:0] rest;
        n  = 0;
        st = ST_OK;
        unique case (k)
            KIND_OPEN:
            begin
                if (link_mode == LINK_OPEN)
                    st = ST_DUP;
                else if (link_mode == LINK_CLOSED)
                    st = ST_CLOSED;
                else
                begin
                    open_sid  = v;
                    link_mode = LINK_OPEN;
                end
            end
            KIND_CLOSE:
                link_mode = LINK_CLOSED;
            KIND_RESET:
            begin
                link_mode  = LINK_IDLE;
                open_sid   = '0;
                pend_count = '0;
                recv_total = '0;
                top_ack    = '0;
            end
            KIND_MARK:
            begin
                if (v >= pend_count)
                    pend_count = '0;
                else
                    pend_count = pend_count - v[CAP_W-1:0];
            end
            KIND_CLEAR:
                pend_count = '0;
            default:
            begin
                if (link_mode != LINK_OPEN)
                    st = ST_INVALID;
                else if (!(k == KIND_INCR && v == 0))
                begin
                    pattern = (k == KIND_ACK) ? 8'h80 : (k == KIND_CANCEL) ? 8'h40 : 8'h00;
                    pmax    = (k == KIND_ACK) ? 62'd127 : 62'd63;
                    if (v < pmax)
                    begin
                        enc[0] = pattern | v[BYTE_W-1:0];
                        n      = 1;
                    end
                    else
                    begin
                        enc[0] = pattern | pmax[BYTE_W-1:0];
                        rest   = v - pmax;
                        n      = 1;
                        while (rest >= 128 && n < DEF_MAX_ENCODED_BYTES - 1)
                        begin
                            enc[n] = {1'b1, rest[6:0]};
                            n++;
                            rest = rest >> 7;
                        end
                        enc[n] = rest[BYTE_W-1:0];
                        n++;
                    end
                    if (n > MAX_RESULTS || int'(pend_count) + n > int'(capacity))
                    begin
                        n  = 0;
                        st = ST_FULL;
                    end
                    else
                    begin
                        pend_count = pend_count + CAP_W'(n);
                        if (k == KIND_ACK && v > top_ack)
                            top_ack = v;
                        else if (k == KIND_INCR)
                            recv_total = recv_total + TOTAL_W'(v);
                    end
                end
            end
        endcase
        if (n == 0)
            push_result('0, 1'b0, 1'b1, st);
        else
            for (int i = 0; i < n; i++)
                push_result(enc[i], 1'b1, i == n - 1, ST_OK);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            errors     = 0;
            capacity   = CAP_RESET;
            link_mode  = LINK_IDLE;
            open_sid   = '0;
            pend_count = '0;
            recv_total = '0;
            top_ack    = '0;
            out_items_q.delete();
            results_awaited <= 0;
        end
        else
        begin
            // compare before queueing: a newly accepted item cannot answer this edge
            if (out_valid && !out_stall)
            begin
                if (out_items_q.size() == 0)
                    report_mismatch("result item with nothing expected", 64'(out_byte), 64'(0));
                else
                begin
                    want = out_items_q.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch("out_byte", 64'(out_byte), 64'(want.data));
                    if (byte_valid !== want.has_byte)
                        report_mismatch("byte_valid", 64'(byte_valid), 64'(want.has_byte));
                    if (last !== want.is_last)
                        report_mismatch("last", 64'(last), 64'(want.is_last));
                    if (status !== want.code)
                        report_mismatch("status", 64'(status), 64'(want.code));
                    if (link_state !== want.link)
                        report_mismatch("link_state", 64'(link_state), 64'(want.link));
                    if (pending_bytes !== want.pend)
                        report_mismatch("pending_bytes", 64'(pending_bytes), 64'(want.pend));
                    if (known_count !== want.total)
                        report_mismatch("known_count", known_count, want.total);
                    if (max_ack_id !== want.ack)
                        report_mismatch("max_ack_id", 64'(max_ack_id), 64'(want.ack));
                    if (open_stream_id !== want.sid)
                        report_mismatch("open_stream_id", 64'(open_stream_id),
                                        64'(want.sid));
                end
            end
            if (psel && penable && pready && paddr[2] == REG_BUFFER_CAPACITY)
            begin
                if (pwrite)
                    capacity = pwdata[CAP_W-1:0];
                else if (prdata[CAP_W-1:0] !== capacity)
                    report_mismatch("buffer_capacity readback", 64'(prdata), 64'(capacity));
            end
            if (in_valid && !in_stall)
                encode_command(kind_t'(kind), operand);
            results_awaited <= out_items_q.size();
        end
    end

endmodule

// ----- bench/qpack_decoder_instruction_encoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpack_decoder_instruction_encoder_test
// drives directed and random decoder stream commands through the encoder with
// bursty input, a stalling output and capacity changes between phases; the
// checker beside the block predicts and compares every result item
// ----------------------------------------------------------------------------
module qpack_decoder_instruction_encoder_test;
    import qpde_pkg::*;

    localparam int                    IDLE_LIMIT = 5000;
    localparam int                    HOLD_LEN   = 300;
    localparam logic [CFG_ADDR_W-1:0] CAP_ADDR   = {REG_BUFFER_CAPACITY, 2'b00};
    localparam logic [OPERAND_W-1:0]  OPND_MAX   = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    kind_t                 cmd_kind;
    logic [OPERAND_W-1:0]  cmd_operand;
    logic                  out_valid;
    logic                  out_stall;
    logic [BYTE_W-1:0]     out_byte;
    logic                  byte_valid;
    logic                  last;
    logic [2:0]            status;
    logic [1:0]            link_state;
    logic [CAP_W-1:0]      pending_bytes;
    logic [TOTAL_W-1:0]    known_count;
    logic [OPERAND_W-1:0]  max_ack_id;
    logic [OPERAND_W-1:0]  open_stream_id;

    int    errors;
    int    results_awaited;
    int    burst_left;
    int    hold_asked;
    int    idle_cycles;
    kind_t prev_kind;

    qpack_decoder_instruction_encoder uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (cmd_kind),
        .operand        (cmd_operand),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .last           (last),
        .status         (status),
        .link_state     (link_state),
        .pending_bytes  (pending_bytes),
        .known_count    (known_count),
        .max_ack_id     (max_ack_id),
        .open_stream_id (open_stream_id)
    );

    qpde_encoder_check enc_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (cmd_kind),
        .operand         (cmd_operand),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .byte_valid      (byte_valid),
        .last            (last),
        .status          (status),
        .link_state      (link_state),
        .pending_bytes   (pending_bytes),
        .known_count     (known_count),
        .max_ack_id      (max_ack_id),
        .open_stream_id  (open_stream_id),
        .errors          (errors),
        .results_awaited (results_awaited)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stall modes, plus a long hold-off whenever one is asked
    initial
    begin
        int hold_done;
        int hold_left;
        int mode;
        int mode_left;
        int tick;
        hold_done = 0;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_done < hold_asked)
            begin
                hold_done++;
                hold_left = HOLD_LEN - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                unique case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 1) == 1);
                    default: out_stall <= (tick % 5 >= 3);
                endcase
            end
        end
    end

    // no progress on either channel for too long means the block is stuck
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_item(input kind_t k, input logic [OPERAND_W-1:0] op);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid    <= 1'b1;
        cmd_kind    <= k;
        cmd_operand <= op;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // wait until every predicted result item has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (results_awaited == 0);
        repeat (4) @(posedge clk);
    endtask

    // write the capacity register, then read it back
    task automatic set_capacity(input logic [CAP_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= {{(CFG_DATA_W-CAP_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [OPERAND_W-1:0] pick_operand();
        logic [63:0] r;
        r = {$urandom, $urandom};
        unique case ($urandom_range(0, 5))
            0:       return OPERAND_W'($urandom_range(0, 70));
            1:       return OPERAND_W'($urandom_range(120, 135));
            2:       return r[OPERAND_W-1:0] >> $urandom_range(0, OPERAND_W - 1);
            3:       return r[OPERAND_W-1:0];
            4:       return OPND_MAX;
            default: return OPERAND_W'($urandom_range(0, 20000));
        endcase
    endfunction

    // mostly instructions on an open link; after close or reset, reopen soon
    task automatic random_items(input int count);
        kind_t                k;
        int                   w;
        logic [OPERAND_W-1:0] op;
        repeat (count)
        begin
            w = $urandom_range(0, 99);
            if (prev_kind == KIND_CLOSE)
                k = (w < 50) ? KIND_OPEN : KIND_RESET;
            else if (prev_kind == KIND_RESET && w < 85)
                k = KIND_OPEN;
            else
            begin
                w = $urandom_range(0, 99);
                if (w < 6)       k = KIND_OPEN;
                else if (w < 10) k = KIND_CLOSE;
                else if (w < 13) k = KIND_RESET;
                else if (w < 38) k = KIND_ACK;
                else if (w < 58) k = KIND_CANCEL;
                else if (w < 80) k = KIND_INCR;
                else if (w < 93) k = KIND_MARK;
                else             k = KIND_CLEAR;
            end
            if (k == KIND_MARK && $urandom_range(0, 3) != 0)
                op = OPERAND_W'($urandom_range(0, 40));
            else
                op = pick_operand();
            send_item(k, op);
            prev_kind = k;
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        cmd_kind    = KIND_OPEN;
        cmd_operand = '0;
        burst_left  = 0;
        hold_asked  = 0;
        prev_kind   = KIND_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // instructions before the link is open
        send_item(KIND_ACK, 62'd5);
        send_item(KIND_MARK, 62'd3);
        send_item(KIND_OPEN, OPND_MAX);
        send_item(KIND_OPEN, 62'd7);
        // prefix boundaries of each instruction
        send_item(KIND_ACK, 62'd0);
        send_item(KIND_ACK, 62'd126);
        send_item(KIND_ACK, 62'd127);
        send_item(KIND_ACK, OPND_MAX);
        send_item(KIND_CANCEL, 62'd62);
        send_item(KIND_CANCEL, 62'd63);
        send_item(KIND_CANCEL, OPND_MAX);
        send_item(KIND_INCR, 62'd0);
        send_item(KIND_INCR, 62'd191);
        send_item(KIND_INCR, OPND_MAX);
        send_item(KIND_MARK, 62'd5);
        send_item(KIND_MARK, OPND_MAX);
        send_item(KIND_CLEAR, 62'd0);
        // closed link refuses open and instructions until reset
        send_item(KIND_CLOSE, 62'd0);
        send_item(KIND_OPEN, 62'd1);
        send_item(KIND_CANCEL, 62'd1);
        send_item(KIND_RESET, OPND_MAX);
        send_item(KIND_OPEN, 62'd0);
        send_item(KIND_CANCEL, OPND_MAX);
        drain();

        // capacity lowered below the pending count, then zero
        set_capacity(16'd4);
        send_item(KIND_CANCEL, 62'd0);
        send_item(KIND_CLEAR, 62'd0);
        send_item(KIND_CANCEL, 62'd63);
        drain();
        set_capacity(16'd0);
        send_item(KIND_ACK, 62'd1);
        drain();

        set_capacity(16'hFFFF);
        random_items(10);
        hold_asked++;
        random_items(20);
        drain();

        set_capacity(16'd1);
        random_items(15);
        drain();

        set_capacity(CAP_W'($urandom_range(16, 200)));
        random_items(20);
        drain();
        random_items(20);
        drain();

        set_capacity(CAP_RESET);
        random_items(10);
        drain();

        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
